### sv/iiee_pkg.sv
// Shared constants, types and helpers for the infix integer expression evaluator.
package iiee_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam int         RADIX      = 10;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } md_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

### sv/iiee_muldiv.sv
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
module iiee_muldiv #(
  parameter int DATA_WIDTH = iiee_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  iiee_pkg::md_ctrl_t     ctrl,
  input  logic [DATA_WIDTH-1:0]  op_a,
  input  logic [DATA_WIDTH-1:0]  op_b,
  output iiee_pkg::md_status_t   stat,
  output logic [DATA_WIDTH-1:0]  result
);
  import iiee_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);

  typedef enum logic [1:0] {MD_IDLE, MD_RUN, MD_SIGN} md_state_t;

  md_state_t             state;
  logic [DATA_WIDTH:0]   acc;
  logic [DATA_WIDTH-1:0] sa;
  logic [DATA_WIDTH-1:0] sb;
  logic                  is_div;
  logic                  neg_q;
  logic                  dz;
  logic [CNT_W-1:0]      cnt;

  logic [DATA_WIDTH-1:0] abs_a;
  logic [DATA_WIDTH-1:0] abs_b;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH:0]   acc_next;
  logic [DATA_WIDTH-1:0] sa_next;
  logic [DATA_WIDTH-1:0] sb_next;

  always_comb begin
    abs_a  = op_a[DATA_WIDTH-1] ? (~op_a + 1'b1) : op_a;
    abs_b  = op_b[DATA_WIDTH-1] ? (~op_b + 1'b1) : op_b;
    rem_sh = {acc[DATA_WIDTH-1:0], sa[DATA_WIDTH-1]};
    diff   = rem_sh - {1'b0, sb};
    if (is_div) begin
      sb_next = sb;
      if (!diff[DATA_WIDTH]) begin
        acc_next = diff;
        sa_next  = {sa[DATA_WIDTH-2:0], 1'b1};
      end else begin
        acc_next = rem_sh;
        sa_next  = {sa[DATA_WIDTH-2:0], 1'b0};
      end
    end else begin
      acc_next = sb[0] ? {1'b0, acc[DATA_WIDTH-1:0] + sa} : acc;
      sa_next  = {sa[DATA_WIDTH-2:0], 1'b0};
      sb_next  = {1'b0, sb[DATA_WIDTH-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= MD_IDLE;
      stat.done     <= 1'b0;
      stat.div_zero <= 1'b0;
      is_div        <= 1'b0;
      dz            <= 1'b0;
    end else begin
      stat.done <= (state == MD_SIGN);
      unique case (state)
        MD_IDLE: begin
          if (ctrl.start) begin
            is_div <= ctrl.is_div;
            acc    <= '0;
            cnt    <= CNT_W'(DATA_WIDTH - 1);
            if (ctrl.is_div) begin
              sb <= abs_b;
              if (op_b == '0) begin
                sa    <= '0;
                neg_q <= 1'b0;
                dz    <= 1'b1;
                state <= MD_SIGN;
              end else begin
                sa    <= abs_a;
                neg_q <= op_a[DATA_WIDTH-1] ^ op_b[DATA_WIDTH-1];
                dz    <= 1'b0;
                state <= MD_RUN;
              end
            end else begin
              sa    <= op_a;
              sb    <= op_b;
              neg_q <= 1'b0;
              dz    <= 1'b0;
              state <= MD_RUN;
            end
          end
        end
        MD_RUN: begin
          acc <= acc_next;
          sa  <= sa_next;
          sb  <= sb_next;
          if (cnt == '0) begin
            state <= MD_SIGN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        MD_SIGN: begin
          if (is_div) begin
            result <= neg_q ? (~sa + 1'b1) : sa;
          end else begin
            result <= acc[DATA_WIDTH-1:0];
          end
          stat.div_zero <= dz;
          state         <= MD_IDLE;
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> (state == MD_IDLE))
    else $error("Multiply or divide started while the unit was busy.");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> !stat.done)
    else $error("Completion lasted more than one cycle.");

  a_dz_div_only: assert property (@(posedge clk) disable iff (rst)
    (stat.done && stat.div_zero) |-> is_div)
    else $error("Division by zero reported for a multiplication.");

endmodule

### sv/infix_int_expression_evaluator.sv
// Top level of the two-precedence infix integer expression evaluator.
// A digit or blank beat that is not the last is taken in S_IDLE alone; other beats go
// on to S_APPLY to apply a pending +, - or unknown operator, or to hand a pending * or
// / to the one-bit-per-cycle multiply and divide unit and wait in S_MULDIV. The last
// beat then loads the output register in S_FINISH, waiting while an earlier result
// still waits there. Reset is synchronous and returns the pending operator to '+'.
module infix_int_expression_evaluator #(
  parameter int DATA_WIDTH = iiee_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [7:0]                   char_code,
  input  logic                         is_last,
  input  logic                         in_valid,
  output logic                         in_ready,
  output logic signed [iiee_pkg::VALUE_W-1:0] value,
  output logic                         div_by_zero,
  output logic                         out_valid,
  input  logic                         out_ready
);
  import iiee_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_APPLY, S_MULDIV, S_FINISH} state_t;

  state_t                       state;
  logic [DATA_WIDTH-1:0]        running_sum;
  logic [DATA_WIDTH-1:0]        last_term;
  logic [DATA_WIDTH-1:0]        pending_number;
  logic [7:0]                   pending_operator;
  logic                         div_error;
  logic [7:0]                   op_char;
  logic                         op_last;

  md_ctrl_t                     md_ctrl;
  md_status_t                   md_stat;
  logic [DATA_WIDTH-1:0]        md_result;
  logic                         accept;
  logic                         digit;
  logic                         blank;
  logic [DATA_WIDTH-1:0]        number_next;
  logic signed [DATA_WIDTH-1:0] total;
  logic                         out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign digit    = is_digit(char_code);
  assign blank    = is_blank(char_code);
  assign out_free = !out_valid || out_ready;
  assign total    = running_sum + last_term;

  always_comb begin
    number_next = (pending_number << 3) + (pending_number << 1)
                + DATA_WIDTH'(char_code - CHAR_ZERO);
    md_ctrl.start  = (state == S_APPLY) &&
                     ((pending_operator == CHAR_STAR) || (pending_operator == CHAR_SLASH));
    md_ctrl.is_div = (pending_operator == CHAR_SLASH);
  end

  iiee_muldiv #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (md_ctrl),
    .op_a   (last_term),
    .op_b   (pending_number),
    .stat   (md_stat),
    .result (md_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      running_sum      <= '0;
      last_term        <= '0;
      pending_number   <= '0;
      pending_operator <= CHAR_PLUS;
      div_error        <= 1'b0;
      out_valid        <= 1'b0;
      op_last          <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (digit) begin
              pending_number <= number_next;
            end
            op_char <= char_code;
            op_last <= is_last;
            if ((!digit && !blank) || is_last) begin
              state <= S_APPLY;
            end
          end
        end
        S_APPLY: begin
          if (md_ctrl.start) begin
            state <= S_MULDIV;
          end else begin
            unique case (pending_operator)
              CHAR_PLUS: begin
                running_sum <= running_sum + last_term;
                last_term   <= pending_number;
              end
              CHAR_MINUS: begin
                running_sum <= running_sum + last_term;
                last_term   <= ~pending_number + 1'b1;
              end
              default: ;
            endcase
            pending_number   <= '0;
            pending_operator <= op_char;
            state            <= op_last ? S_FINISH : S_IDLE;
          end
        end
        S_MULDIV: begin
          if (md_stat.done) begin
            last_term        <= md_result;
            div_error        <= div_error | md_stat.div_zero;
            pending_number   <= '0;
            pending_operator <= op_char;
            state            <= op_last ? S_FINISH : S_IDLE;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            value            <= VALUE_W'(total);
            div_by_zero      <= div_error;
            out_valid        <= 1'b1;
            running_sum      <= '0;
            last_term        <= '0;
            pending_number   <= '0;
            pending_operator <= CHAR_PLUS;
            div_error        <= 1'b0;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_muldiv: assert property (@(posedge clk) disable iff (rst)
    md_stat.done |-> (state == S_MULDIV))
    else $error("Multiply or divide finished outside its wait state.");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && out_free) |=>
      (running_sum == '0 && last_term == '0 && pending_operator == CHAR_PLUS && !div_error
       && out_valid))
    else $error("State not returned to its start values after a result.");

  a_dz_sticky: assert property (@(posedge clk) disable iff (rst)
    (md_stat.done && md_stat.div_zero) |=> div_error)
    else $error("Division by zero not recorded.");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the infix integer expression evaluator, with its own predictor.
module tb;
  import iiee_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_BEATS = 950;
  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    logic [7:0] code;
    logic       last;
    logic       drain;
  } char_beat_t;

  typedef struct {
    logic [31:0] value;
    logic        dz;
  } expr_result_t;

  logic clk;
  logic rst = 1'b1;
  logic [7:0] char_code = '0;
  logic is_last = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [VALUE_W-1:0] value;
  logic div_by_zero;
  logic out_valid;
  logic out_ready = 1'b0;

  char_beat_t pending_chars[$];
  expr_result_t expected_results[$];
  logic [7:0] expr_chars[$];
  char_beat_t next_beat;
  expr_result_t got_want;

  logic [31:0] sum_acc = '0;
  logic [31:0] term_acc = '0;
  logic [31:0] num_acc = '0;
  logic [7:0]  op_held = CHAR_PLUS;
  logic        dz_seen = 1'b0;

  int beats_total = 0;
  int beats_sent = 0;
  int errors = 0;
  int cycles = 0;
  logic quiet;

  infix_int_expression_evaluator DUT (
    .clk(clk),
    .rst(rst),
    .char_code(char_code),
    .is_last(is_last),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .div_by_zero(div_by_zero),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

  assign quiet = (beats_sent >= 300) && (beats_sent < 550);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic eval_char(input logic [7:0] c, input logic last);
    logic dig;
    logic blk;
    logic [31:0] ua;
    logic [31:0] ub;
    logic [31:0] q;
    expr_result_t r;
    dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    blk = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    if (dig) begin
      num_acc = num_acc * 32'(RADIX) + {24'd0, c - CHAR_ZERO};
    end
    if ((!dig && !blk) || last) begin
      case (op_held)
        CHAR_PLUS: begin
          sum_acc = sum_acc + term_acc;
          term_acc = num_acc;
        end
        CHAR_MINUS: begin
          sum_acc = sum_acc + term_acc;
          term_acc = -num_acc;
        end
        CHAR_STAR: begin
          term_acc = term_acc * num_acc;
        end
        CHAR_SLASH: begin
          ua = term_acc[31] ? -term_acc : term_acc;
          ub = num_acc[31] ? -num_acc : num_acc;
          if (ub == '0) begin
            dz_seen = 1'b1;
            term_acc = '0;
          end else begin
            q = ua / ub;
            term_acc = (term_acc[31] ^ num_acc[31]) ? -q : q;
          end
        end
        default: ;
      endcase
      num_acc = '0;
      op_held = c;
    end
    if (last) begin
      r.value = sum_acc + term_acc;
      r.dz = dz_seen;
      expected_results.push_back(r);
      sum_acc = '0;
      term_acc = '0;
      num_acc = '0;
      op_held = CHAR_PLUS;
      dz_seen = 1'b0;
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
  endtask

  task automatic add_blanks();
    int b;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        b = $urandom_range(CHAR_TAB, CHAR_CR + 1);
        expr_chars.push_back((b > CHAR_CR) ? CHAR_SPACE : 8'(b));
      end
    end
  endtask

  task automatic add_operator();
    case ($urandom_range(19))
      0: expr_chars.push_back(8'($urandom_range(255)));
      1, 2, 3, 4, 5: expr_chars.push_back(CHAR_PLUS);
      6, 7, 8, 9, 10: expr_chars.push_back(CHAR_MINUS);
      11, 12, 13, 14, 15: expr_chars.push_back(CHAR_STAR);
      default: expr_chars.push_back(CHAR_SLASH);
    endcase
  endtask

  task automatic add_number();
    int r;
    longint unsigned v;
    r = $urandom_range(99);
    if (r < 50) begin
      v = $urandom_range(9);
    end else if (r < 80) begin
      v = $urandom_range(999);
    end else if (r < 90) begin
      case ($urandom_range(4))
        0: v = 0;
        1: v = 64'd2147483648;
        2: v = 64'd4294967295;
        3: v = 64'd4294967296;
        default: v = 64'd2147483647;
      endcase
    end else begin
      v = {$urandom, $urandom} % 64'd1000000000000;
    end
    add_text($sformatf("%0d", v));
  endtask

  task automatic flush_expr(input logic drain);
    char_beat_t b;
    for (int i = 0; i < expr_chars.size(); i++) begin
      b.code = expr_chars[i];
      b.last = (i == expr_chars.size() - 1);
      b.drain = drain && (i == 0);
      pending_chars.push_back(b);
    end
    expr_chars.delete();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      char_code <= '0;
      is_last <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        eval_char(char_code, is_last);
        beats_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_chars.size() != 0
            && !(pending_chars[0].drain && expected_results.size() != 0)
            && (quiet || $urandom_range(99) >= 20)) begin
          next_beat = pending_chars.pop_front();
          in_valid <= 1'b1;
          char_code <= next_beat.code;
          is_last <= next_beat.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: value=%0d div_by_zero=%0b", value, div_by_zero);
          errors++;
        end else begin
          got_want = expected_results.pop_front();
          if (value !== got_want.value) begin
            $error("value: expected %0d, actual %0d", $signed(got_want.value), value);
            errors++;
          end
          if (div_by_zero !== got_want.dz) begin
            $error("div_by_zero: expected %0b, actual %0b", got_want.dz, div_by_zero);
            errors++;
          end
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int n_expr;
    int kind;
    int directed_beats;
    n_expr = 0;

    add_text("8-2*3/0");
    expr_chars.push_back(CHAR_TAB);
    flush_expr(1'b0);
    add_text("1+");
    expr_chars.push_back(8'hFF);
    add_text("3");
    flush_expr(1'b0);
    add_text("2147483648/4294967295");
    flush_expr(1'b0);
    expr_chars.push_back(8'h00);
    flush_expr(1'b0);
    directed_beats = pending_chars.size();

    while (pending_chars.size() < directed_beats + RANDOM_BEATS) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        repeat ($urandom_range(1, 8)) expr_chars.push_back(8'($urandom_range(255)));
      end else begin
        if ($urandom_range(9) == 0) add_operator();
        for (int t = 0; t < $urandom_range(1, 5); t++) begin
          if (t > 0) begin
            add_blanks();
            add_operator();
          end
          add_blanks();
          add_number();
        end
        case ($urandom_range(9))
          0: expr_chars.push_back(CHAR_SPACE);
          1: add_operator();
          2: expr_chars.push_back(8'($urandom_range(255)));
          default: ;
        endcase
      end
      flush_expr(n_expr % 37 == 0);
      n_expr++;
    end
    beats_total = pending_chars.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (beats_sent != beats_total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
